/* hw/rtl/twda_pkg.sv */
// ----------------------------------------------------------------------------
// twda_pkg
// Shared widths, types and constants of the time-window delay average block.
// ----------------------------------------------------------------------------
package twda_pkg;

    // ring store depth and derived widths
    localparam int DEPTH      = 64;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // field widths
    localparam int TIME_W     = 31;
    localparam int DELAY_W    = 24;
    localparam int WIN_W      = 16;
    localparam int COUNT_W    = 7;

    // one store entry holds the stamp and the sample
    localparam int ENTRY_W    = TIME_W + DELAY_W;

    // running sum of DEPTH samples, and the rounded numerator
    localparam int SUM_W      = DELAY_W + ADDR_W;
    localparam int NUM_W      = SUM_W + 1;
    localparam int STEP_W     = $clog2(NUM_W + 1);

    // count widened so the 7-bit report can always be sliced from it
    localparam int CNT_WIDE_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(4000);

    typedef logic        [TIME_W-1:0]  t_time;
    typedef logic signed [DELAY_W-1:0] t_delay;
    typedef logic        [WIN_W-1:0]   t_window;
    typedef logic        [COUNT_W-1:0] t_count;

endpackage

/* hw/rtl/twda_if.sv */
// ----------------------------------------------------------------------------
// twda channel interfaces
// Valid/ready channels for samples, results and the window register.
// ----------------------------------------------------------------------------

// sample channel
interface twda_sample_if
    import twda_pkg::*;
;
    logic    valid;
    logic    ready;
    t_time   now_ms;
    t_delay  delay_sample;

    modport source (output valid, output now_ms, output delay_sample, input ready);
    modport sink   (input valid, input now_ms, input delay_sample, output ready);
endinterface

// result channel
interface twda_result_if
    import twda_pkg::*;
;
    logic    valid;
    logic    ready;
    t_delay  average_delay;
    t_count  sample_count;

    modport source (output valid, output average_delay, output sample_count, input ready);
    modport sink   (input valid, input average_delay, input sample_count, output ready);
endinterface

// window register write channel
interface twda_cfg_if
    import twda_pkg::*;
;
    logic    valid;
    logic    ready;
    t_window window_ms;

    modport source (output valid, output window_ms, input ready);
    modport sink   (input valid, input window_ms, output ready);
endinterface

/* hw/rtl/twda_ram.sv */
// ----------------------------------------------------------------------------
// twda_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module twda_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/time_window_delay_average.sv */
// ----------------------------------------------------------------------------
// time_window_delay_average
// Rounded moving average of latency samples over a sliding time window.
// ----------------------------------------------------------------------------
// Each sample transaction appends {now_ms, delay_sample} to a 64-entry ring
// held in one RAM with a registered read port, dropping the oldest entry
// first when the ring is full, then drops entries from the oldest end while
// their stamp + window_ms <= now_ms, always keeping the newest one. A result
// transaction returns (sum + count/2) / count, truncated toward zero, and the
// number of samples kept. Each entry aged out costs one RAM read and one
// check, and the quotient comes from a 31-step restoring divider. One item
// is in work at a time; the next sample is taken while the previous result
// still waits in the output register.
// The window register may be written at any time the block is idle.
// ----------------------------------------------------------------------------
module time_window_delay_average
    import twda_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    twda_sample_if.sink      i_sample,
    twda_result_if.source    o_result,
    twda_cfg_if.sink         i_cfg
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DROP_FULL,
        ST_WRITE,
        ST_EV_RD,
        ST_EV_CHK,
        ST_DIV,
        ST_DONE
    } t_state;

    t_state                   r_state,     n_state;
    logic [ADDR_W-1:0]        r_oldest,    n_oldest;
    logic [CNT_W-1:0]         r_count,     n_count;
    logic signed [SUM_W-1:0]  r_sum,       n_sum;
    t_window                  r_window,    n_window;
    t_time                    r_now,       n_now;
    t_delay                   r_sample,    n_sample;
    logic [NUM_W-1:0]         r_quo,       n_quo;
    logic [CNT_W-1:0]         r_rem,       n_rem;
    logic                     r_neg,       n_neg;
    logic [STEP_W-1:0]        r_step,      n_step;
    logic                     r_out_valid, n_out_valid;
    t_delay                   r_out_avg,   n_out_avg;
    t_count                   r_out_cnt,   n_out_cnt;

    logic                     ram_wr_en;
    logic [ADDR_W-1:0]        wr_slot;
    logic [ADDR_W:0]          slot_sum;
    logic [ENTRY_W-1:0]       rd_data;
    t_time                    rd_stamp;
    t_delay                   rd_delay;
    logic [ADDR_W-1:0]        oldest_inc;
    logic                     aged;
    logic signed [NUM_W-1:0]  num;
    logic [NUM_W-1:0]         num_mag;
    logic [CNT_W:0]           rem_shift;
    logic                     rem_ge;
    logic [CNT_W:0]           rem_sub;
    logic signed [NUM_W-1:0]  quo_signed;
    logic [CNT_WIDE_W-1:0]    count_wide;
    logic                     sample_acc;
    logic                     div_start;

    // entry store
    twda_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (wr_slot),
        .i_wr_data ({r_now, r_sample}),
        .i_rd_addr (r_oldest),
        .o_rd_data (rd_data)
    );

    assign rd_stamp = rd_data[ENTRY_W-1 -: TIME_W];
    assign rd_delay = rd_data[DELAY_W-1:0];

    // handshakes
    assign i_sample.ready = (r_state == ST_IDLE);
    assign sample_acc     = i_sample.valid && i_sample.ready;
    assign i_cfg.ready    = 1'b1;

    assign o_result.valid         = r_out_valid;
    assign o_result.average_delay = r_out_avg;
    assign o_result.sample_count  = r_out_cnt;

    // ring slot arithmetic
    assign slot_sum   = {1'b0, r_oldest} + (ADDR_W+1)'(r_count);
    assign wr_slot    = (slot_sum >= (ADDR_W+1)'(DEPTH))
                      ? ADDR_W'(slot_sum - (ADDR_W+1)'(DEPTH))
                      : slot_sum[ADDR_W-1:0];
    assign oldest_inc = (r_oldest == ADDR_W'(DEPTH - 1)) ? '0 : r_oldest + 1'b1;
    assign ram_wr_en  = (r_state == ST_WRITE);

    // age check: stamp <= now - window, without wrap
    assign aged = ({1'b0, rd_stamp} + (TIME_W+1)'(r_window)) <= {1'b0, r_now};

    // rounded numerator and its magnitude
    assign num     = NUM_W'(r_sum) + NUM_W'(r_count >> 1);
    assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : num;

    // one restoring division step
    assign rem_shift = {r_rem, r_quo[NUM_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, r_count};
    assign rem_sub   = rem_shift - {1'b0, r_count};

    assign quo_signed = r_neg ? NUM_W'(-r_quo) : r_quo;
    assign count_wide = CNT_WIDE_W'(r_count);

    // next-state logic
    always_comb begin
        n_state     = r_state;
        n_oldest    = r_oldest;
        n_count     = r_count;
        n_sum       = r_sum;
        n_window    = r_window;
        n_now       = r_now;
        n_sample    = r_sample;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_neg       = r_neg;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        n_out_avg   = r_out_avg;
        n_out_cnt   = r_out_cnt;
        div_start   = 1'b0;

        // result register empties when the transaction completes
        if (o_result.valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        // window register write
        if (i_cfg.valid && i_cfg.ready) begin
            n_window = i_cfg.window_ms;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (sample_acc) begin
                    n_now    = i_sample.now_ms;
                    n_sample = i_sample.delay_sample;
                    n_state  = (r_count == CNT_W'(DEPTH)) ? ST_DROP_FULL : ST_WRITE;
                end
            end
            ST_DROP_FULL: begin
                // oldest entry read is valid now
                n_sum    = r_sum - SUM_W'(rd_delay);
                n_oldest = oldest_inc;
                n_count  = r_count - 1'b1;
                n_state  = ST_WRITE;
            end
            ST_WRITE: begin
                n_sum   = r_sum + SUM_W'(r_sample);
                n_count = r_count + 1'b1;
                n_state = ST_EV_RD;
            end
            ST_EV_RD: begin
                // read of the oldest entry is under way
                if (r_count > CNT_W'(1)) begin
                    n_state = ST_EV_CHK;
                end else begin
                    div_start = 1'b1;
                end
            end
            ST_EV_CHK: begin
                if (aged) begin
                    n_sum    = r_sum - SUM_W'(rd_delay);
                    n_oldest = oldest_inc;
                    n_count  = r_count - 1'b1;
                    n_state  = ST_EV_RD;
                end else begin
                    div_start = 1'b1;
                end
            end
            ST_DIV: begin
                n_quo  = {r_quo[NUM_W-2:0], rem_ge};
                n_rem  = rem_ge ? rem_sub[CNT_W-1:0] : rem_shift[CNT_W-1:0];
                n_step = r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid = 1'b1;
                    n_out_avg   = quo_signed[DELAY_W-1:0];
                    n_out_cnt   = count_wide[COUNT_W-1:0];
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // load the divider
        if (div_start) begin
            n_quo   = num_mag;
            n_rem   = '0;
            n_neg   = num[NUM_W-1];
            n_step  = STEP_W'(NUM_W);
            n_state = ST_DIV;
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_oldest    <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_window    <= WINDOW_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_oldest    <= n_oldest;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_window    <= n_window;
            r_out_valid <= n_out_valid;
            r_now       <= n_now;
            r_sample    <= n_sample;
            r_quo       <= n_quo;
            r_rem       <= n_rem;
            r_neg       <= n_neg;
            r_step      <= n_step;
            r_out_avg   <= n_out_avg;
            r_out_cnt   <= n_out_cnt;
        end
    end

endmodule
